>>> hdl/iu2x_pkg.sv
// Shared types and constants for the 2x bilinear upscaler.
`default_nettype none
package iu2x_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ROW_CNT_W  = 12;
  localparam int COL_CNT_W  = 10;
  localparam int ROWS_W     = 13;
  localparam int COLS_W     = 11;
  localparam int OUT_ROW_W  = 13;
  localparam int OUT_COL_W  = 11;
  localparam int PIXEL_W    = 18;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_COLS_DEF = 1024;
  localparam int COLS_LIMIT   = 1024;
  localparam int ROWS_LIMIT   = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ROWS = 1'b0,
    REG_IN_COLS = 1'b1
  } cfg_reg_e;

  // Position of a result inside the 3x3 neighborhood around one sample:
  // LO is row 2r-1 or column 2c-1, MID is 2r or 2c, HI is 2r+1 or 2c+1.
  typedef enum logic [1:0] {
    SEL_LO  = 2'd0,
    SEL_MID = 2'd1,
    SEL_HI  = 2'd2
  } sel_e;

  typedef struct packed {
    logic [ROW_CNT_W-1:0] row;
    logic [COL_CNT_W-1:0] col;
    logic [SAMPLE_W-1:0]  sample;
    logic [SAMPLE_W-1:0]  up;
    logic                 has_top;
    logic                 has_left;
    logic                 last_col;
    logic                 last_row;
  } job_t;

endpackage
`default_nettype wire

>>> hdl/iu2x_line_mem.sv
// Line buffer: one row of samples, synchronous read with write forwarding.
`default_nettype none
module iu2x_line_mem #(
  parameter int DEPTH = iu2x_pkg::MAX_COLS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic [iu2x_pkg::SAMPLE_W-1:0]      rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  wire logic [iu2x_pkg::SAMPLE_W-1:0] wr_data_i
);
  import iu2x_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic [SAMPLE_W-1:0] fwd_data_q;
  logic                fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Take the written word when a read hits the entry written in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

>>> hdl/iu2x_emit.sv
// Result sequencer: holds neighbor samples and walks the results of one sample.
`default_nettype none
module iu2x_emit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire iu2x_pkg::job_t                 job_i,
  output logic                                free_o,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output logic [iu2x_pkg::OUT_ROW_W-1:0]      res_row_o,
  output logic [iu2x_pkg::OUT_COL_W-1:0]      res_col_o,
  output logic [iu2x_pkg::PIXEL_W-1:0]        res_value_o,
  output logic                                res_last_o
);
  import iu2x_pkg::*;

  job_t                  job_q;
  logic                  busy_q;
  sel_e                  dr_q, dr_d;
  sel_e                  dc_q, dc_d;
  logic [PIXEL_W-1:0]    sum4_q;
  logic [SAMPLE_W:0]     sum_up_q;
  logic [SAMPLE_W:0]     sum_lf_q;
  logic [SAMPLE_W-1:0]   ul_q;
  logic [SAMPLE_W-1:0]   lf_q;
  logic [SAMPLE_W:0]     sum_up_d;
  logic [SAMPLE_W:0]     sum_lf_d;
  sel_e                  row_end, col_first, col_end;
  logic                  at_end;
  logic                  fire;
  logic [OUT_ROW_W:0]    row_full;
  logic [OUT_COL_W:0]    col_full;

  function automatic sel_e sel_inc(sel_e v);
    sel_e r;
    unique case (v)
      SEL_LO:  r = SEL_MID;
      SEL_MID: r = SEL_HI;
      default: r = SEL_HI;
    endcase
    return r;
  endfunction

  assign row_end   = job_q.last_row ? SEL_HI : SEL_MID;
  assign col_first = job_q.has_left ? SEL_LO : SEL_MID;
  assign col_end   = job_q.last_col ? SEL_HI : SEL_MID;

  assign at_end = (dr_q == row_end) && (dc_q == col_end);
  assign fire   = busy_q && res_ready_i;
  assign free_o = !busy_q || (fire && at_end);

  assign sum_up_d = {1'b0, job_i.up} + {1'b0, job_i.sample};
  assign sum_lf_d = {1'b0, lf_q} + {1'b0, job_i.sample};

  always_comb begin
    dr_d = dr_q;
    dc_d = dc_q;
    if (load_i) begin
      dr_d = job_i.has_top  ? SEL_LO : SEL_MID;
      dc_d = job_i.has_left ? SEL_LO : SEL_MID;
    end else if (fire && !at_end) begin
      if (dc_q == col_end) begin
        dc_d = col_first;
        dr_d = sel_inc(dr_q);
      end else begin
        dc_d = sel_inc(dc_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dr_q   <= SEL_MID;
      dc_q   <= SEL_MID;
      ul_q   <= '0;
      lf_q   <= '0;
    end else begin
      dr_q <= dr_d;
      dc_q <= dc_d;
      if (load_i) begin
        busy_q <= 1'b1;
        ul_q   <= job_i.up;
        lf_q   <= job_i.sample;
      end else if (fire && at_end) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q    <= job_i;
      sum_up_q <= sum_up_d;
      sum_lf_q <= sum_lf_d;
      sum4_q   <= PIXEL_W'(sum_up_d) + PIXEL_W'(ul_q) + PIXEL_W'(lf_q);
    end
  end

  always_comb begin
    res_value_o = '0;
    unique case (dr_q)
      SEL_LO: begin
        unique case (dc_q)
          SEL_LO:  res_value_o = sum4_q;
          SEL_MID: res_value_o = {sum_up_q, 1'b0};
          default: res_value_o = PIXEL_W'(sum_up_q);
        endcase
      end
      SEL_MID: begin
        unique case (dc_q)
          SEL_LO:  res_value_o = {sum_lf_q, 1'b0};
          SEL_MID: res_value_o = {job_q.sample, 2'b00};
          default: res_value_o = PIXEL_W'({job_q.sample, 1'b0});
        endcase
      end
      default: begin
        unique case (dc_q)
          SEL_LO:  res_value_o = PIXEL_W'(sum_lf_q);
          SEL_MID: res_value_o = PIXEL_W'({job_q.sample, 1'b0});
          default: res_value_o = PIXEL_W'(job_q.sample);
        endcase
      end
    endcase
  end

  // Output coordinate is twice the input position, offset by -1, 0 or +1.
  assign row_full = {1'b0, job_q.row, 1'b0} + (OUT_ROW_W + 1)'(dr_q) - (OUT_ROW_W + 1)'(1);
  assign col_full = {1'b0, job_q.col, 1'b0} + (OUT_COL_W + 1)'(dc_q) - (OUT_COL_W + 1)'(1);

  assign res_row_o   = row_full[OUT_ROW_W-1:0];
  assign res_col_o   = col_full[OUT_COL_W-1:0];
  assign res_valid_o = busy_q;
  assign res_last_o  = at_end;

endmodule
`default_nettype wire

>>> hdl/image_upscale_2x_bilinear.sv
// Top level of the 2x bilinear upscaler: counters, line buffer read and result stream.
// Samples enter in raster order; each yields 1 to 9 upscaled pixels (4 in the body of
// the image, more on an even last row or column), sent one per cycle while the master
// stream is ready, so the sustained pace is one sample per its result count, bound by
// the single result port. A sample is taken whenever the result sequencer is free or
// finishing its last beat; each input beat is held in a register while its upper
// neighbor is read from the line buffer, then loaded into the result sequencer. The
// line buffer needs no clearing after reset: an entry's value is used only on rows
// after the first of a frame. Any register write restarts the frame.
`default_nettype none
module image_upscale_2x_bilinear #(
  parameter int MAX_COLS = iu2x_pkg::MAX_COLS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [iu2x_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [15:0] sample
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [iu2x_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // [12:0] out_row,
                                                                // [23:13] out_col,
                                                                // [41:24] pixel_value
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [iu2x_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [iu2x_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import iu2x_pkg::*;

  localparam int LINE_DEPTH = (MAX_COLS < COLS_LIMIT) ? MAX_COLS : COLS_LIMIT;
  localparam int AW         = $clog2(LINE_DEPTH);

  logic [ROWS_W-1:0]    rows_q;
  logic [COLS_W-1:0]    cols_q;
  logic [ROWS_W-1:0]    rows_eff;
  logic [COLS_W-1:0]    cols_eff;
  logic [ROW_CNT_W-1:0] row_q;
  logic [COL_CNT_W-1:0] col_q;
  logic                 in_fire;
  logic                 cfg_fire;
  logic                 col_wrap;
  logic                 row_wrap;

  logic                 s1_v_q;
  job_t                 s1_q;
  job_t                 job;
  logic                 emit_free;
  logic                 xfer;
  logic [SAMPLE_W-1:0]  up_data;

  logic [OUT_ROW_W-1:0] res_row;
  logic [OUT_COL_W-1:0] res_col;
  logic [PIXEL_W-1:0]   res_value;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    rows_eff = rows_q;
    if (rows_q == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (rows_q > ROWS_W'(ROWS_LIMIT)) begin
      rows_eff = ROWS_W'(ROWS_LIMIT);
    end
    cols_eff = cols_q;
    if (cols_q == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cols_q > COLS_W'(LINE_DEPTH)) begin
      cols_eff = COLS_W'(LINE_DEPTH);
    end
  end

  assign xfer          = s1_v_q && emit_free;
  assign s_axis_tready = !s1_v_q || xfer;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign col_wrap = ({1'b0, col_q} + COLS_W'(1)) >= cols_eff;
  assign row_wrap = ({1'b0, row_q} + ROWS_W'(1)) >= rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_W'(1);
      cols_q <= COLS_W'(1);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IN_ROWS: rows_q <= cfg_data_i;
        REG_IN_COLS: cols_q <= cfg_data_i[COLS_W-1:0];
        default:     rows_q <= rows_q;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + ROW_CNT_W'(1);
      end else begin
        col_q <= col_q + COL_CNT_W'(1);
      end
    end
  end

  // Hold the sample here while its upper neighbor is read from the line buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (xfer) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.row      <= row_q;
      s1_q.col      <= col_q;
      s1_q.sample   <= s_axis_tdata[SAMPLE_W-1:0];
      s1_q.up       <= '0;
      s1_q.has_top  <= row_q != '0;
      s1_q.has_left <= col_q != '0;
      s1_q.last_col <= !cols_eff[0] && ({1'b0, col_q} == cols_eff - COLS_W'(1));
      s1_q.last_row <= !rows_eff[0] && ({1'b0, row_q} == rows_eff - ROWS_W'(1));
    end
  end

  iu2x_line_mem #(
    .DEPTH (LINE_DEPTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q[AW-1:0]),
    .rd_data_o (up_data),
    .wr_en_i   (xfer),
    .wr_addr_i (s1_q.col[AW-1:0]),
    .wr_data_i (s1_q.sample)
  );

  always_comb begin
    job    = s1_q;
    job.up = up_data;
  end

  iu2x_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (xfer),
    .job_i       (job),
    .free_o      (emit_free),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_row_o   (res_row),
    .res_col_o   (res_col),
    .res_value_o (res_value),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {
    (OUT_DATA_W - OUT_ROW_W - OUT_COL_W - PIXEL_W)'(0), res_value, res_col, res_row
  };

endmodule
`default_nettype wire
